// File: rtl/dqne_pkg.sv
// Shared constants, codes and types of the DNS query name extractor.
`default_nettype none
package dqne_pkg;

   localparam int HEADER_BYTES  = 12;
   localparam int MAX_LABEL_LEN = 63;

   localparam logic [7:0] DOT_CHAR = 8'd46;

   // Result queue geometry.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LEN    = 2'd1,
      PH_LABEL  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_DOT  = 2'd1,
      KIND_OK   = 2'd2,
      KIND_BAD  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last;
   } rsp_item_type;

   // Up to two results per parsed byte; second implies first.
   typedef struct packed {
      logic         v0;
      logic         v1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   typedef struct packed {
      logic [FIFO_LVL_W-1:0] level;
      logic                  room2;
   } fifo_status_type;

endpackage
`default_nettype wire

// File: rtl/dns_query_name_extractor_core.sv
// Top level of the DNS query name extractor: input register, parser, result queue.
//
// Usage:
// The req channel carries a DNS query packet one byte per transfer, with
// req_tlast high on the packet's final byte. The block skips the 12 header
// bytes, then walks the question name's labels. The rsp channel returns name
// characters (tuser 0), a dot before each label after the first (tuser 1),
// and one status per packet, ok (tuser 2) or invalid (tuser 3), marked by
// rsp_tlast. On an invalid status the consumer drops the characters it got.
// Path: a byte is held in the input register until the result queue has room for
// two results; it then moves on, its results are written into the queue, and rsp
// returns them from there in order.
// Throughput: one byte per cycle while the receiver takes results. A final byte
// that ends inside or at the end of a label gives two results; the four-entry
// result queue absorbs the extra one, since header bytes give none.
// Reset is synchronous and active high; it empties the queue and returns the
// parser to the header phase. When the receiver stalls, results wait in the
// queue and req_tready falls once a byte is held and under two entries are free.
`default_nettype none
module dns_query_name_extractor_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic       req_tlast,   // end_of_packet
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [1:0]      rsp_tuser,   // [1:0] kind
   output logic            rsp_tlast    // last
);

   // Input register stage.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eop_ff;

   logic req_fire;
   logic advance;

   dqne_pkg::push_type        push;
   dqne_pkg::rsp_item_type    head;
   dqne_pkg::fifo_status_type fifo_status;
   logic                      head_valid;

   // The held byte moves on only when the queue can take two results.
   assign advance    = in_valid_ff && fifo_status.room2;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_eop_ff  <= req_tlast;
      end
   end

   dqne_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item_byte  (in_byte_ff),
      .item_eop   (in_eop_ff),
      .push       (push)
   );

   dqne_result_fifo u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .head       (head),
      .head_valid (head_valid),
      .head_taken (rsp_tready),
      .status     (fifo_status)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = head.out_byte;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   // The queue never holds more entries than it has.
   assert property (@(posedge clock) disable iff (reset)
      fifo_status.level <= dqne_pkg::FIFO_LVL_W'(dqne_pkg::FIFO_DEPTH))
      else $error("result queue level exceeds its depth");

   // A status result always closes the name, and only a status does.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (rsp_tuser == dqne_pkg::KIND_OK) || (rsp_tuser == dqne_pkg::KIND_BAD))
      else $error("last result is not a status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         (rsp_tuser == dqne_pkg::KIND_CHAR) || (rsp_tuser == dqne_pkg::KIND_DOT))
      else $error("status result without last");

   // Back pressure on req comes only from a held byte that cannot move on.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && !fifo_status.room2)
      else $error("req stalled without a blocked byte");

endmodule
`default_nettype wire

// File: rtl/dqne_parser.sv
// Header skip and label walk state machine producing name and status results.
`default_nettype none
module dqne_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire logic [7:0]        item_byte,
   input  wire logic              item_eop,
   output dqne_pkg::push_type     push
);

   dqne_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          header_count_ff, header_count_in;
   logic [5:0]          label_remaining_ff, label_remaining_in;
   logic                label_seen_ff, label_seen_in;

   logic [4:0] header_sum;
   logic [5:0] remaining_dec;
   logic       len_zero;
   logic       len_too_long;

   assign header_sum    = {1'b0, header_count_ff} + 5'd1;
   assign remaining_dec = (label_remaining_ff != 6'd0) ? label_remaining_ff - 6'd1
                                                       : label_remaining_ff;
   assign len_zero      = (item_byte == 8'd0);
   assign len_too_long  = (item_byte > 8'(dqne_pkg::MAX_LABEL_LEN));

   // Next state.
   always_comb begin
      phase_in           = phase_ff;
      header_count_in    = header_count_ff;
      label_remaining_in = label_remaining_ff;
      label_seen_in      = label_seen_ff;
      if (item_valid) begin
         unique case (phase_ff)
            dqne_pkg::PH_HEADER: begin
               if (!item_eop) begin
                  if (header_sum >= 5'(dqne_pkg::HEADER_BYTES)) begin
                     header_count_in = 4'd0;
                     phase_in        = dqne_pkg::PH_LEN;
                  end else begin
                     header_count_in = header_sum[3:0];
                  end
               end
            end
            dqne_pkg::PH_LEN: begin
               if (len_zero || len_too_long || item_eop) begin
                  phase_in = dqne_pkg::PH_DONE;
               end else begin
                  label_seen_in      = 1'b1;
                  label_remaining_in = item_byte[5:0];
                  phase_in           = dqne_pkg::PH_LABEL;
               end
            end
            dqne_pkg::PH_LABEL: begin
               label_remaining_in = remaining_dec;
               if (remaining_dec == 6'd0) begin
                  phase_in = dqne_pkg::PH_LEN;
               end
            end
            dqne_pkg::PH_DONE: begin
            end
         endcase
         // The final byte always returns the walker to the header phase.
         if (item_eop) begin
            phase_in           = dqne_pkg::PH_HEADER;
            header_count_in    = 4'd0;
            label_remaining_in = 6'd0;
            label_seen_in      = 1'b0;
         end
      end
   end

   // Results.
   always_comb begin
      push = '0;
      if (item_valid) begin
         unique case (phase_ff)
            dqne_pkg::PH_HEADER: begin
               if (item_eop) begin
                  push.v0    = 1'b1;
                  push.item0 = '{out_byte: 8'd0, kind: dqne_pkg::KIND_BAD, last: 1'b1};
               end
            end
            dqne_pkg::PH_LEN: begin
               if (len_zero) begin
                  push.v0    = 1'b1;
                  push.item0 = '{out_byte: 8'd0,
                                 kind: label_seen_ff ? dqne_pkg::KIND_OK : dqne_pkg::KIND_BAD,
                                 last: 1'b1};
               end else if (len_too_long || item_eop) begin
                  push.v0    = 1'b1;
                  push.item0 = '{out_byte: 8'd0, kind: dqne_pkg::KIND_BAD, last: 1'b1};
               end else if (label_seen_ff) begin
                  push.v0    = 1'b1;
                  push.item0 = '{out_byte: dqne_pkg::DOT_CHAR, kind: dqne_pkg::KIND_DOT,
                                 last: 1'b0};
               end
            end
            dqne_pkg::PH_LABEL: begin
               push.v0    = 1'b1;
               push.item0 = '{out_byte: item_byte, kind: dqne_pkg::KIND_CHAR, last: 1'b0};
               if (item_eop) begin
                  push.v1    = 1'b1;
                  push.item1 = '{out_byte: 8'd0,
                                 kind: (remaining_dec == 6'd0) ? dqne_pkg::KIND_OK
                                                               : dqne_pkg::KIND_BAD,
                                 last: 1'b1};
               end
            end
            dqne_pkg::PH_DONE: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= dqne_pkg::PH_HEADER;
         header_count_ff    <= 4'd0;
         label_remaining_ff <= 6'd0;
         label_seen_ff      <= 1'b0;
      end else begin
         phase_ff           <= phase_in;
         header_count_ff    <= header_count_in;
         label_remaining_ff <= label_remaining_in;
         label_seen_ff      <= label_seen_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/dqne_result_fifo.sv
// Small result queue taking up to two results per cycle and giving at most one.
`default_nettype none
module dqne_result_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dqne_pkg::push_type        push,
   output dqne_pkg::rsp_item_type         head,
   output logic                           head_valid,
   input  wire logic                      head_taken,
   output dqne_pkg::fifo_status_type      status
);

   dqne_pkg::rsp_item_type mem_ff [dqne_pkg::FIFO_DEPTH];

   logic [dqne_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dqne_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dqne_pkg::FIFO_LVL_W-1:0] level_ff, level_in;
   logic [dqne_pkg::FIFO_PTR_W-1:0] wr_ptr_next;
   logic                            pop;

   assign pop         = head_taken && head_valid;
   assign wr_ptr_next = wr_ptr_ff + dqne_pkg::FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + dqne_pkg::FIFO_PTR_W'(push.v0)
                            + dqne_pkg::FIFO_PTR_W'(push.v1);
      rd_ptr_in = rd_ptr_ff + dqne_pkg::FIFO_PTR_W'(pop);
      level_in  = level_ff + dqne_pkg::FIFO_LVL_W'(push.v0)
                           + dqne_pkg::FIFO_LVL_W'(push.v1)
                           - dqne_pkg::FIFO_LVL_W'(pop);
   end

   assign head_valid   = (level_ff != '0);
   assign head         = mem_ff[rd_ptr_ff];
   assign status.level = level_ff;
   assign status.room2 = (level_ff <= dqne_pkg::FIFO_LVL_W'(dqne_pkg::FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push.v0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.v1) begin
         mem_ff[wr_ptr_next] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule
`default_nettype wire
